/* design/mclbs_pkg.sv */
// Shared types and constants for the multi-channel LED blink scheduler.
// No dependencies; mclbs_chan_update and the top level import this package.
`default_nettype none

package mclbs_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ON    = 2'd1,
        OP_OFF   = 2'd2,
        OP_SCHED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_ON    = 2'd0,
        MODE_OFF   = 2'd1,
        MODE_BLINK = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_TICK,
        ST_FINISH
    } seq_state_t;

    localparam logic [15:0] FLASH_FOREVER = 16'hFFFF;

    // One channel's stored state, kept as one memory word.
    typedef struct packed {
        mode_t       mode;
        logic [7:0]  delay_left;
        logic [7:0]  phase_countdown;
        logic        phase_high;
        logic [15:0] flashes_left;
        logic [7:0]  on_reload;
        logic [7:0]  off_reload;
    } chan_state_t;

    localparam chan_state_t CHAN_RESET = '{
        mode:            MODE_OFF,
        delay_left:      8'd0,
        phase_countdown: 8'd0,
        phase_high:      1'b0,
        flashes_left:    16'd0,
        on_reload:       8'd0,
        off_reload:      8'd0
    };

endpackage

`default_nettype wire

/* design/mclbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mclbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/mclbs_chan_update.sv */
// Advances one channel by one tick: delay, phase countdown, toggle, flash count.
// Depends on mclbs_pkg.
`default_nettype none

module mclbs_chan_update
    import mclbs_pkg::*;
(
    input  wire chan_state_t cur,
    input  wire logic        level_cur,
    output chan_state_t      nxt,
    output logic             level_nxt,
    output logic             done
);

    always_comb
    begin
        nxt       = cur;
        level_nxt = level_cur;
        done      = 1'b0;
        unique case (cur.mode)
            MODE_OFF:
            begin
                level_nxt = 1'b0;
            end
            MODE_ON:
            begin
                level_nxt = 1'b1;
            end
            default:
            begin
                // Blinking; the unused mode code behaves the same way.
                if (cur.delay_left != 8'd0)
                begin
                    nxt.delay_left = cur.delay_left - 8'd1;
                end
                else if (cur.phase_countdown != 8'd0)
                begin
                    nxt.phase_countdown = cur.phase_countdown - 8'd1;
                end
                else if (!cur.phase_high)
                begin
                    level_nxt           = 1'b1;
                    nxt.phase_high      = 1'b1;
                    nxt.phase_countdown = cur.on_reload;
                    if (cur.flashes_left != FLASH_FOREVER)
                    begin
                        if (cur.flashes_left == 16'd0)
                        begin
                            nxt.mode = MODE_OFF;
                            done     = 1'b1;
                        end
                        else
                        begin
                            nxt.flashes_left = cur.flashes_left - 16'd1;
                        end
                    end
                end
                else
                begin
                    level_nxt           = 1'b0;
                    nxt.phase_high      = 1'b0;
                    nxt.phase_countdown = cur.off_reload;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/multi_channel_led_blink_scheduler.sv */
// Top level of the multi-channel LED blink scheduler: sequencer, state memory, output register.
// Depends on mclbs_pkg, mclbs_ram and mclbs_chan_update.
//
// Each input word is either a tick or a command to one channel, and yields exactly one
// output word with the pin levels and the finished flags. All channel state sits in one
// memory with registered reads; a tick walks it one channel per cycle with a pipelined
// read-modify-write, and the block takes no new word until a tick or command is done.
// Reset needs no clearing pass: a valid flag per entry makes unwritten entries read as
// their reset value. The output register lets the next word be taken while a finished
// result is still waiting to be picked up.
`default_nettype none

module multi_channel_led_blink_scheduler
    import mclbs_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [2:0]  channel,
    input  wire logic [7:0]  start_delay,
    input  wire logic [7:0]  on_ticks,
    input  wire logic [7:0]  off_ticks,
    input  wire logic [15:0] flash_count,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [7:0]  pin_levels,
    output logic      [7:0]  finished_mask
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LVL_W  = (CHANNELS > 8) ? CHANNELS : 8;
    localparam int WORD_W = $bits(chan_state_t);

    seq_state_t          state_reg, state_next;
    op_t                 op_reg;
    logic                cmd_ok_reg;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic [7:0]          delay_reg, on_reg, off_reg;
    logic [15:0]         flash_reg;
    logic [LVL_W-1:0]    level_reg, level_next;
    logic [7:0]          fin_reg, fin_next;
    logic [CHANNELS-1:0] valid_reg, valid_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          pin_reg, finmask_reg;
    logic                load_out;

    logic                accept;
    logic                ram_we, ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    chan_state_t         cur_state, upd_state, wr_state;
    logic                upd_level, upd_done;
    logic                last_chan;

    mclbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (wr_state),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // An entry never written since reset reads as its reset value.
    assign cur_state = (valid_reg[addr_reg]) ? chan_state_t'(ram_rdata) : CHAN_RESET;

    mclbs_chan_update u_update (
        .cur       (cur_state),
        .level_cur (level_reg[addr_reg]),
        .nxt       (upd_state),
        .level_nxt (upd_level),
        .done      (upd_done)
    );

    assign accept    = in_valid && !in_stall;
    assign last_chan = (addr_reg == IDX_W'(CHANNELS - 1));

    always_comb
    begin
        wr_state = cur_state;
        unique case (op_reg)
            OP_ON:
            begin
                wr_state.mode = MODE_ON;
            end
            OP_OFF:
            begin
                wr_state.mode = MODE_OFF;
            end
            OP_SCHED:
            begin
                wr_state.delay_left   = delay_reg;
                wr_state.on_reload    = on_reg;
                wr_state.off_reload   = off_reg;
                wr_state.flashes_left = flash_reg;
                wr_state.mode         = MODE_BLINK;
            end
            OP_TICK:
            begin
                wr_state = upd_state;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        in_stall       = 1'b1;
        ram_re         = 1'b0;
        ram_raddr      = addr_reg;
        ram_we         = 1'b0;
        level_next     = level_reg;
        fin_next       = fin_reg;
        valid_next     = valid_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    addr_next  = (op_t'(op) == OP_TICK) ? '0 : IDX_W'(channel);
                    ram_re     = 1'b1;
                    ram_raddr  = addr_next;
                    fin_next   = 8'd0;
                    state_next = (op_t'(op) == OP_TICK) ? ST_TICK : ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (cmd_ok_reg)
                begin
                    ram_we               = 1'b1;
                    valid_next[addr_reg] = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_TICK:
            begin
                ram_we               = 1'b1;
                valid_next[addr_reg] = 1'b1;
                level_next[addr_reg] = upd_level;
                fin_next             = fin_reg | (8'(upd_done) << addr_reg);
                if (last_chan)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    // Read the next channel while this one is written back.
                    addr_next  = addr_reg + IDX_W'(1);
                    ram_re     = 1'b1;
                    ram_raddr  = addr_next;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_TICK;
            addr_reg      <= '0;
            level_reg     <= '0;
            fin_reg       <= 8'd0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (accept)
            begin
                op_reg <= op_t'(op);
            end
            addr_reg      <= addr_next;
            level_reg     <= level_next;
            fin_reg       <= fin_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_ok_reg <= (int'(channel) < CHANNELS);
            delay_reg  <= start_delay;
            on_reg     <= on_ticks;
            off_reg    <= off_ticks;
            flash_reg  <= flash_count;
        end
        if (load_out)
        begin
            pin_reg     <= level_reg[7:0];
            finmask_reg <= fin_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pin_levels    = pin_reg;
    assign finished_mask = finmask_reg;

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_raddr != addr_reg)
        else $error("state memory read and written at the same entry");

    a_finish_is_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (finished_mask & ~pin_levels) == 8'd0)
        else $error("finished channel not driven high on its last flash");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CMD || state_reg == ST_TICK))
        else $error("accepted word did not start a command or tick");

    a_write_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CMD || state_reg == ST_TICK))
        else $error("state memory written outside command or tick work");

endmodule

`default_nettype wire

/* tb/tb_multi_channel_led_blink_scheduler.sv */
// Self-checking testbench for the multi-channel LED blink scheduler.
// Depends on mclbs_pkg and multi_channel_led_blink_scheduler; the expected pin levels
// and finished flags come from a channel-by-channel predictor kept inside this file.
`timescale 1ns / 100ps

module tb_multi_channel_led_blink_scheduler
    import mclbs_pkg::*;
();

    localparam int NCH = 8;
    localparam int RANDOM_WORDS = 1725;
    localparam int CYCLE_LIMIT = 800000;
    localparam int HOLD_AFTER_WORDS = 500;
    localparam int HOLD_LENGTH = 400;

    typedef struct packed {
        op_t         op;
        logic [2:0]  channel;
        logic [7:0]  start_delay;
        logic [7:0]  on_ticks;
        logic [7:0]  off_ticks;
        logic [15:0] flash_count;
    } led_word_t;

    typedef struct packed {
        logic [7:0] pins;
        logic [7:0] finished;
    } led_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = '0;
    logic [2:0]  channel = '0;
    logic [7:0]  start_delay = '0;
    logic [7:0]  on_ticks = '0;
    logic [7:0]  off_ticks = '0;
    logic [15:0] flash_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  pin_levels;
    logic [7:0]  finished_mask;

    // Predicted per-channel state.
    mode_t       led_mode [NCH];
    logic [7:0]  wait_left [NCH];
    logic [7:0]  count_left [NCH];
    bit          high_phase [NCH];
    logic [15:0] flashes [NCH];
    logic [7:0]  on_len [NCH];
    logic [7:0]  off_len [NCH];
    bit          lit [NCH];

    led_word_t   pending_words[$];
    led_result_t expected_leds[$];
    led_result_t want;
    led_word_t   next_word;

    int  mismatches = 0;
    int  words_accepted = 0;
    int  send_idle = 0;
    int  stall_run = 0;
    int  hold_cycles = 0;
    bit  hold_done = 1'b0;
    int  cycle_count = 0;
    bit  calm;

    multi_channel_led_blink_scheduler #(
        .CHANNELS(NCH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .channel      (channel),
        .start_delay  (start_delay),
        .on_ticks     (on_ticks),
        .off_ticks    (off_ticks),
        .flash_count  (flash_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pin_levels   (pin_levels),
        .finished_mask(finished_mask)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Every fourth stretch of 150 words runs with no random gaps and no random stalls.
    assign calm = ((words_accepted / 150) % 4) == 3;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] wanted);
        $display("mismatch at word %0d: %s got %02h wanted %02h", words_accepted, what,
                 got, wanted);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic bit tick_channel(input int i);
        bit done;
        done = 1'b0;
        case (led_mode[i])
            MODE_OFF: lit[i] = 1'b0;
            MODE_ON:  lit[i] = 1'b1;
            default:
            begin
                if (wait_left[i] != 0)
                    wait_left[i]--;
                else if (count_left[i] != 0)
                    count_left[i]--;
                else if (!high_phase[i])
                begin
                    lit[i] = 1'b1;
                    high_phase[i] = 1'b1;
                    count_left[i] = on_len[i];
                    if (flashes[i] != FLASH_FOREVER)
                    begin
                        // The flash that starts with no count left ends the blinking.
                        if (flashes[i] == 0)
                        begin
                            led_mode[i] = MODE_OFF;
                            done = 1'b1;
                        end
                        else
                            flashes[i]--;
                    end
                end
                else
                begin
                    lit[i] = 1'b0;
                    high_phase[i] = 1'b0;
                    count_left[i] = off_len[i];
                end
            end
        endcase
        return done;
    endfunction

    // Applies one accepted word to the predicted state and queues the result it causes.
    task automatic step_leds(input led_word_t w);
        led_result_t res;
        int ch;
        res.finished = '0;
        ch = int'(w.channel);
        case (w.op)
            OP_TICK:
                for (int i = 0; i < NCH; i++)
                    res.finished[i] = tick_channel(i);
            OP_ON:  led_mode[ch] = MODE_ON;
            OP_OFF: led_mode[ch] = MODE_OFF;
            default:
            begin
                // Scheduling leaves the phase and its countdown untouched.
                wait_left[ch] = w.start_delay;
                on_len[ch] = w.on_ticks;
                off_len[ch] = w.off_ticks;
                flashes[ch] = w.flash_count;
                led_mode[ch] = MODE_BLINK;
            end
        endcase
        for (int i = 0; i < NCH; i++)
            res.pins[i] = lit[i];
        expected_leds.push_back(res);
    endtask

    task automatic add_word(input op_t o, input logic [2:0] ch, input logic [7:0] sd,
                            input logic [7:0] on_t, input logic [7:0] off_t,
                            input logic [15:0] fc);
        led_word_t w;
        w.op = o;
        w.channel = ch;
        w.start_delay = sd;
        w.on_ticks = on_t;
        w.off_ticks = off_t;
        w.flash_count = fc;
        pending_words.push_back(w);
    endtask

    task automatic add_ticks(input int n);
        repeat (n)
            add_word(OP_TICK, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom));
    endtask

    task automatic add_random_word();
        int r;
        logic [15:0] fc;
        r = $urandom_range(0, 99);
        if (r < 50)
            add_ticks(1);
        else if (r < 58)
            add_word(OP_ON, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom));
        else if (r < 66)
            add_word(OP_OFF, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom));
        else if (r < 94)
        begin
            // Short schedules, so that delays run out and flashes finish often.
            if ($urandom_range(0, 9) == 0)
                fc = FLASH_FOREVER;
            else
                fc = 16'($urandom_range(0, 4));
            add_word(OP_SCHED, 3'($urandom), 8'($urandom_range(0, 3)),
                     8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), fc);
        end
        else
            add_word(OP_SCHED, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom));
    endtask

    // Driver: offers the pending words in order, with random gaps after each.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_idle = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                step_leds({op_t'(op), channel, start_delay, on_ticks, off_ticks,
                           flash_count});
                words_accepted <= words_accepted + 1;
            end
            if (!(in_valid && in_stall))
            begin
                if (send_idle > 0)
                begin
                    send_idle--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    next_word = pending_words.pop_front();
                    op <= next_word.op;
                    channel <= next_word.channel;
                    start_delay <= next_word.start_delay;
                    on_ticks <= next_word.on_ticks;
                    off_ticks <= next_word.off_ticks;
                    flash_count <= next_word.flash_count;
                    in_valid <= 1'b1;
                    send_idle = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // One long hold on the output side while the driver keeps offering words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
        else if (!hold_done && words_accepted >= HOLD_AFTER_WORDS)
        begin
            hold_cycles <= HOLD_LENGTH;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_run = 0;
        end
        else
        begin
            if (stall_run > 0)
                stall_run--;
            else
                stall_run = pick_gap();
            out_stall <= (hold_cycles != 0) || (stall_run > 0);
        end
    end

    // Monitor: checks every accepted result word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_leds.size() == 0)
                report_mismatch("unexpected word, pin_levels", pin_levels, 8'h00);
            else
            begin
                want = expected_leds.pop_front();
                if (pin_levels !== want.pins)
                    report_mismatch("pin_levels", pin_levels, want.pins);
                if (finished_mask !== want.finished)
                    report_mismatch("finished_mask", finished_mask, want.finished);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d words still expected", expected_leds.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NCH; i++)
        begin
            led_mode[i] = MODE_OFF;
            wait_left[i] = '0;
            count_left[i] = '0;
            high_phase[i] = 1'b0;
            flashes[i] = '0;
            on_len[i] = '0;
            off_len[i] = '0;
            lit[i] = 1'b0;
        end

        // Commands only show on the pins after the next tick.
        add_ticks(1);
        add_word(OP_ON, 3'd0, 8'h00, 8'h00, 8'h00, 16'h0000);
        add_word(OP_ON, 3'd7, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        add_ticks(1);
        add_word(OP_OFF, 3'd0, 8'hFF, 8'h00, 8'hFF, 16'h0000);
        // A zero flash count finishes on the first rising edge, then drops low.
        add_word(OP_SCHED, 3'd1, 8'd0, 8'd0, 8'd0, 16'd0);
        add_ticks(2);
        add_word(OP_SCHED, 3'd2, 8'd2, 8'd1, 8'd0, 16'd1);
        add_word(OP_SCHED, 3'd3, 8'hFF, 8'hFF, 8'hFF, FLASH_FOREVER);
        add_word(OP_SCHED, 3'd4, 8'd1, 8'd0, 8'd2, 16'hFFFE);
        add_ticks(8);
        // Rescheduling mid-blink keeps the current phase.
        add_word(OP_SCHED, 3'd2, 8'd0, 8'd3, 8'd3, 16'd2);
        add_ticks(4);
        add_word(OP_OFF, 3'd3, 8'h00, 8'h00, 8'h00, 16'h0000);
        add_ticks(1);

        repeat (RANDOM_WORDS)
            add_random_word();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || in_valid || expected_leds.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
design/mclbs_pkg.sv
design/mclbs_ram.sv
design/mclbs_chan_update.sv
design/multi_channel_led_blink_scheduler.sv
tb/tb_multi_channel_led_blink_scheduler.sv
